// File: rtl/core/drat_proof_line_encoder_unit_macros.svh
// Assertion helpers for the proof line encoder.
`ifndef DRAT_PROOF_LINE_ENCODER_UNIT_MACROS_SVH
`define DRAT_PROOF_LINE_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DPLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dple assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define DPLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dple assertion failed: next-cycle check");

`endif

// File: rtl/core/dple_pkg.sv
package dple_pkg;

   // Input token codes.
   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_DEL = 2'd1;
   localparam logic [1:0] FUNC_LIT = 2'd2;
   localparam logic [1:0] FUNC_END = 2'd3;

   // Proof stream characters.
   localparam logic [7:0] CHAR_A       = 8'h61;
   localparam logic [7:0] CHAR_D       = 8'h64;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] VARINT_CONT  = 8'h80;

   localparam int DIGITS    = 10;
   localparam int BCD_W     = 4 * DIGITS;
   localparam int MAG_W     = 32;
   localparam int CONV_BITS = 4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_SIGN,
      S_DIGIT,
      S_SPACE,
      S_VARINT,
      S_TOK1,
      S_TOK2
   } state_type;

   typedef enum logic [3:0] {
      SEL_A,
      SEL_D,
      SEL_MINUS,
      SEL_SPACE,
      SEL_ZERO_CHAR,
      SEL_NEWLINE,
      SEL_NUL,
      SEL_DIGIT,
      SEL_VARINT
   } byte_sel_type;

   typedef struct packed {
      logic         load;
      logic         conv_step;
      logic         digit_init;
      logic         digit_next;
      logic         varint_shift;
      logic         emit;
      logic         last;
      byte_sel_type sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       binary_mode;
      logic [1:0] func;
      logic       in_lit_zero;
      logic       neg;
      logic       conv_last;
      logic       digit_last;
      logic       varint_more;
   } dp_status_type;

endpackage

// File: rtl/core/dple_datapath.sv
module dple_datapath import dple_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_literal,
   input  logic               csr_write,
   input  logic               csr_wdata,
   output dp_status_type      status,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_of_run
);

   localparam int CNT_W = $clog2(MAG_W / CONV_BITS);
   localparam int IDX_W = $clog2(DIGITS);
   localparam int DD_W  = BCD_W + MAG_W;

   logic                 mode_ff;
   logic [1:0]           func_ff;
   logic                 neg_ff;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic [BCD_W-1:0]     bcd_ff;
   logic [MAG_W:0]       varint_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [IDX_W-1:0]     idx_ff, lead_idx;
   logic [DD_W-1:0]      dabble_out;
   logic                 strobe_ff;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff;
   logic                 varint_more;

   // Several double-dabble steps: correct every BCD digit, then shift one bit in.
   function automatic logic [DD_W-1:0] dabble(input logic [DD_W-1:0] v);
      logic [DD_W-1:0] t;
      t = v;
      for (int s = 0; s < CONV_BITS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (t[MAG_W + 4*d +: 4] >= 4'd5) begin
               t[MAG_W + 4*d +: 4] = t[MAG_W + 4*d +: 4] + 4'd3;
            end
         end
         t = t << 1;
      end
      return t;
   endfunction

   assign mag_in      = req_literal[31] ? (~req_literal + 32'd1) : req_literal;
   assign dabble_out  = dabble({bcd_ff, mag_ff});
   assign varint_more = (varint_ff[MAG_W:7] != '0);

   always_comb begin
      lead_idx = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            lead_idx = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_write) begin
         mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_func;
         neg_ff    <= req_literal[31];
         mag_ff    <= mag_in;
         bcd_ff    <= '0;
         varint_ff <= {mag_in, req_literal[31]};
         cnt_ff    <= '0;
      end else begin
         if (cmd.conv_step) begin
            {bcd_ff, mag_ff} <= dabble_out;
            cnt_ff           <= cnt_ff + 1'b1;
         end
         if (cmd.varint_shift) begin
            varint_ff <= varint_ff >> 7;
         end
      end
      if (cmd.digit_init) begin
         idx_ff <= lead_idx;
      end else if (cmd.digit_next) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   always_comb begin
      unique case (cmd.sel)
         SEL_A:         byte_in = CHAR_A;
         SEL_D:         byte_in = CHAR_D;
         SEL_MINUS:     byte_in = CHAR_MINUS;
         SEL_SPACE:     byte_in = CHAR_SPACE;
         SEL_ZERO_CHAR: byte_in = CHAR_ZERO;
         SEL_NEWLINE:   byte_in = CHAR_NEWLINE;
         SEL_NUL:       byte_in = CHAR_NUL;
         SEL_DIGIT:     byte_in = CHAR_ZERO | {4'h0, bcd_ff[{idx_ff, 2'b00} +: 4]};
         SEL_VARINT:    byte_in = (varint_more ? VARINT_CONT : 8'h00) | {1'b0, varint_ff[6:0]};
         default:       byte_in = CHAR_NUL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
      byte_ff <= byte_in;
      last_ff <= cmd.last;
   end

   assign status.binary_mode = mode_ff;
   assign status.func        = func_ff;
   assign status.in_lit_zero = (req_literal == 32'sd0);
   assign status.neg         = neg_ff;
   assign status.conv_last   = (cnt_ff == {CNT_W{1'b1}});
   assign status.digit_last  = (idx_ff == '0);
   assign status.varint_more = varint_more;

   assign rsp_strobe      = strobe_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// File: rtl/core/dple_ctrl.sv
module dple_ctrl import dple_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_func,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   state_type state_ff, state_in;
   logic      tok1_last;

   // Whether the first byte of a fixed token ends its run.
   always_comb begin
      unique case (status.func)
         FUNC_ADD: tok1_last = 1'b1;
         FUNC_DEL: tok1_last = status.binary_mode;
         default:  tok1_last = status.binary_mode;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_func == FUNC_LIT) begin
                  if (status.in_lit_zero) begin
                     state_in = S_IDLE;
                  end else if (status.binary_mode) begin
                     state_in = S_VARINT;
                  end else begin
                     state_in = S_CONV;
                  end
               end else if (req_func == FUNC_ADD && !status.binary_mode) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_TOK1;
               end
            end
         end
         S_CONV:   if (status.conv_last) state_in = S_SIGN;
         S_SIGN:   state_in = S_DIGIT;
         S_DIGIT:  if (status.digit_last) state_in = S_SPACE;
         S_SPACE:  state_in = S_IDLE;
         S_VARINT: if (!status.varint_more) state_in = S_IDLE;
         S_TOK1:   state_in = tok1_last ? S_IDLE : S_TOK2;
         S_TOK2:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '{load: 1'b0, conv_step: 1'b0, digit_init: 1'b0, digit_next: 1'b0,
              varint_shift: 1'b0, emit: 1'b0, last: 1'b0, sel: SEL_NUL};
      unique case (state_ff)
         S_IDLE: cmd.load = start;
         S_CONV: cmd.conv_step = 1'b1;
         S_SIGN: begin
            cmd.digit_init = 1'b1;
            cmd.emit       = status.neg;
            cmd.sel        = SEL_MINUS;
         end
         S_DIGIT: begin
            cmd.emit       = 1'b1;
            cmd.digit_next = 1'b1;
            cmd.sel        = SEL_DIGIT;
         end
         S_SPACE: begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            cmd.sel  = SEL_SPACE;
         end
         S_VARINT: begin
            cmd.emit         = 1'b1;
            cmd.last         = !status.varint_more;
            cmd.varint_shift = 1'b1;
            cmd.sel          = SEL_VARINT;
         end
         S_TOK1: begin
            cmd.emit = 1'b1;
            cmd.last = tok1_last;
            unique case (status.func)
               FUNC_ADD: cmd.sel = SEL_A;
               FUNC_DEL: cmd.sel = SEL_D;
               default:  cmd.sel = status.binary_mode ? SEL_NUL : SEL_ZERO_CHAR;
            endcase
         end
         S_TOK2: begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            cmd.sel  = (status.func == FUNC_DEL) ? SEL_SPACE : SEL_NEWLINE;
         end
         default: cmd.emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: rtl/core/drat_proof_line_encoder_unit.sv
// A token's or binary literal's first byte is emitted from the first state after acceptance; a
// negative text literal's '-' from the sign state after the conversion states, then digits.
// Throughput: one output byte per cycle while a run streams; a word keeps the unit busy until
// its last byte is emitted, and no new word is accepted while it is busy.
// Reset (synchronous, active high) returns the controller to idle and selects text mode.
// The receiver cannot stall: every result is presented for exactly one cycle on rsp_strobe.
`include "drat_proof_line_encoder_unit_macros.svh"

module drat_proof_line_encoder_unit import dple_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Input word: accepted when start is high and busy is low.
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_literal,
   // Result word: one byte per strobe.
   output logic               rsp_strobe,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_of_run,
   // Mode register write channel.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Writes always land; the user must change the mode register only while the unit is idle.
   assign csr_ready = 1'b1;

   // The controller sequences each word: fixed tokens go to at most two emit states, nonzero
   // binary literals stream seven bits of the varint per cycle, and nonzero text literals
   // run an iterative binary-to-BCD conversion, four bits per cycle, before digits stream out.
   dple_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // The datapath holds the captured word, the conversion registers, the mode register and
   // the registered output byte.
   dple_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_func        (req_func),
      .req_literal     (req_literal),
      .csr_write       (csr_valid && csr_ready),
      .csr_wdata       (csr_wdata),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // A byte that does not end its run must be followed by more, so the unit is still busy.
   `DPLE_ASSERT_NOW(a_mid_run_busy, clock, reset, rsp_strobe && !rsp_last_of_run, busy)
   // The final byte of a run is never directly followed by another byte.
   `DPLE_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_strobe && rsp_last_of_run, !rsp_strobe)
   // Accepting a word happens only in idle, which emits nothing in that cycle.
   `DPLE_ASSERT_NEXT(a_accept_quiet, clock, reset, start && !busy, !rsp_strobe)

endmodule
